FILE: hdl/overwriting_history_ring_buffer_assert.svh
// Assertion macros for the history ring buffer
`ifndef OVERWRITING_HISTORY_RING_BUFFER_ASSERT_SVH
`define OVERWRITING_HISTORY_RING_BUFFER_ASSERT_SVH

// condition holds at every edge out of reset
`define OHRB_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ring buffer check failed");

// same-cycle implication
`define OHRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ring buffer check failed");

// next-cycle implication
`define OHRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ring buffer check failed");

`endif

FILE: hdl/ohrb_pkg.sv
// Shared types and constants of the history ring buffer
package ohrb_pkg;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int TIME_W = 48;
  localparam int POS_W  = 6;
  localparam int END_W  = 7;
  localparam int MS_W   = 32;
  localparam int FILL_W = 7;

  localparam int S_TDATA_W = 160;
  localparam int M_TDATA_W = 88;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_GET    = 3'd1,
    OP_RANGE  = 3'd2,
    OP_WINDOW = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_REF  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // commands from the sequencer to the cell chain
  typedef struct packed {
    logic push;    // new sample enters
    logic wrap;    // ring full: shift out the oldest, new sample at the tail
    logic rotate;  // whole chain rotates one place towards cell 0
  } chain_ctl_t;

  typedef struct packed {
    logic              found;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] time_ms;
    logic              last;
    logic [FILL_W-1:0] fill;
  } res_t;

endpackage

FILE: hdl/overwriting_history_ring_buffer.sv
// Push / clear: result word the cycle after acceptance; pushes each cycle unless output stalls.
// Get and range get: one lap of the rotating cell chain, or none when the request is out of range.
// Time-window query: one lap to fetch the reference time, a second to match.
// Results leave at up to one word per cycle in a lap; a stall halts it only if a match is due.
// Reset clears the fill count, sequencer state and output valid; cells keep their contents.
module overwriting_history_ring_buffer #(
  parameter int DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_value[31:0], sample_time_ms[79:32], position[85:80], range_end[92:86],
  // before_ms[124:93], after_ms[156:125], zero pad above
  input  logic [ohrb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation[2:0]
  input  logic [ohrb_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // entry_value[31:0], entry_time_ms[79:32], fill_count[86:80], zero pad above
  output logic [ohrb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import ohrb_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [VAL_W-1:0]  new_val;
  logic [TIME_W-1:0] new_time;
  logic [POS_W-1:0]  pos;
  logic [END_W-1:0]  rend;
  logic [MS_W-1:0]   before_ms, after_ms;
  logic [VAL_W-1:0]  cell_val  [DEPTH];
  logic [TIME_W-1:0] cell_time [DEPTH];
  logic [CntW-1:0]   count;
  chain_ctl_t        ctl;
  res_t              res;

  assign new_val   = s_axis_tdata[31:0];
  assign new_time  = s_axis_tdata[79:32];
  assign pos       = s_axis_tdata[85:80];
  assign rend      = s_axis_tdata[92:86];
  assign before_ms = s_axis_tdata[124:93];
  assign after_ms  = s_axis_tdata[156:125];

  ohrb_ctrl #(
    .DEPTH (DEPTH),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s_axis_tvalid),
    .in_rdy_o   (s_axis_tready),
    .op_i       (s_axis_tuser),
    .pos_i      (pos),
    .rend_i     (rend),
    .before_i   (before_ms),
    .after_i    (after_ms),
    .tap_val_i  (cell_val[0]),
    .tap_time_i (cell_time[0]),
    .out_rdy_i  (m_axis_tready),
    .out_vld_o  (m_axis_tvalid),
    .out_o      (res),
    .ctl_o      (ctl),
    .count_o    (count)
  );

  // between operations cell 0 holds the oldest entry; a lap rotates towards cell 0
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    localparam int NB = (gi == DEPTH - 1) ? 0 : gi + 1;
    logic ld, sh;

    assign ld = ctl.push && (ctl.wrap ? (gi == DEPTH - 1) : (count == CntW'(gi)));
    assign sh = ctl.rotate || (ctl.push && ctl.wrap);

    ohrb_cell u_cell (
      .clk_i      (clk_i),
      .ld_i       (ld),
      .sh_i       (sh),
      .new_val_i  (new_val),
      .new_time_i (new_time),
      .nb_val_i   (cell_val[NB]),
      .nb_time_i  (cell_time[NB]),
      .val_o      (cell_val[gi]),
      .time_o     (cell_time[gi])
    );
  end

  assign m_axis_tdata = {1'b0, res.fill, res.time_ms, res.value};
  assign m_axis_tuser = res.found;
  assign m_axis_tlast = res.last;

`include "overwriting_history_ring_buffer_assert.svh"

  `OHRB_ASSERT_HOLDS(a_fill_bound, count <= CntW'(DEPTH))
  `OHRB_ASSERT_HOLDS(a_no_push_in_lap, !(ctl.push && ctl.rotate))
  `OHRB_ASSERT_NEXT(a_push_status, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PUSH), m_axis_tvalid && m_axis_tlast && !m_axis_tuser)
  `OHRB_ASSERT_IMP(a_empty_is_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)

endmodule

FILE: hdl/ohrb_cell.sv
// One storage cell of the sample chain
module ohrb_cell (
  input  logic                       clk_i,
  input  logic                       ld_i,
  input  logic                       sh_i,
  input  logic [ohrb_pkg::VAL_W-1:0]  new_val_i,
  input  logic [ohrb_pkg::TIME_W-1:0] new_time_i,
  input  logic [ohrb_pkg::VAL_W-1:0]  nb_val_i,
  input  logic [ohrb_pkg::TIME_W-1:0] nb_time_i,
  output logic [ohrb_pkg::VAL_W-1:0]  val_o,
  output logic [ohrb_pkg::TIME_W-1:0] time_o
);
  import ohrb_pkg::*;

  logic [VAL_W-1:0]  val_q;
  logic [TIME_W-1:0] time_q;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      val_q  <= new_val_i;
      time_q <= new_time_i;
    end else if (sh_i) begin
      val_q  <= nb_val_i;
      time_q <= nb_time_i;
    end
  end

  assign val_o  = val_q;
  assign time_o = time_q;

endmodule

FILE: hdl/ohrb_ctrl.sv
// Sequencer: operation decode, chain walk, match logic and output word register
module ohrb_ctrl #(
  parameter int DEPTH = 64,
  parameter int CntW  = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_vld_i,
  output logic                        in_rdy_o,
  input  logic [ohrb_pkg::OP_W-1:0]   op_i,
  input  logic [ohrb_pkg::POS_W-1:0]  pos_i,
  input  logic [ohrb_pkg::END_W-1:0]  rend_i,
  input  logic [ohrb_pkg::MS_W-1:0]   before_i,
  input  logic [ohrb_pkg::MS_W-1:0]   after_i,
  input  logic [ohrb_pkg::VAL_W-1:0]  tap_val_i,
  input  logic [ohrb_pkg::TIME_W-1:0] tap_time_i,
  input  logic                        out_rdy_i,
  output logic                        out_vld_o,
  output ohrb_pkg::res_t              out_o,
  output ohrb_pkg::chain_ctl_t        ctl_o,
  output logic [CntW-1:0]             count_o
);
  import ohrb_pkg::*;

  localparam int CW  = (CntW > END_W) ? CntW : END_W;
  localparam int TW1 = TIME_W + 1;

  state_e            state_q, state_d;
  op_e               op_q;
  logic [CW-1:0]     pos_q, end_q, end_d;
  logic [MS_W-1:0]   before_q, after_q;
  logic [TIME_W-1:0] tref_q, tref_d;
  logic [CntW-1:0]   step_q, step_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pend_vld_q, pend_vld_d;
  logic [VAL_W-1:0]  pend_val_q;
  logic [TIME_W-1:0] pend_time_q;
  logic              pend_ld;
  logic              out_vld_q;
  res_t              out_q, out_nx;
  logic              load_out;
  logic              can_load, accept, full, step_last, in_win, match;
  logic [CW-1:0]     j, cnt_w, pos_w, rend_w;

  assign can_load  = !out_vld_q || out_rdy_i;
  assign in_rdy_o  = (state_q == ST_IDLE) && can_load;
  assign accept    = in_vld_i && in_rdy_o;
  assign full      = count_q == CntW'(DEPTH);
  assign step_last = step_q == CntW'(DEPTH - 1);
  assign j         = CW'(step_q);
  assign cnt_w     = CW'(count_q);
  assign pos_w     = CW'(pos_i);
  assign rend_w    = CW'(rend_i);

  // tref - before <= t <= tref + after, kept unsigned by moving terms across
  assign in_win = (TW1'(tap_time_i) + TW1'(before_q) >= TW1'(tref_q)) &&
                  (TW1'(tap_time_i) <= TW1'(tref_q) + TW1'(after_q));

  always_comb begin
    unique case (op_q)
      OP_GET:    match = j == pos_q;
      OP_RANGE:  match = (j >= pos_q) && (j < end_q);
      OP_WINDOW: match = (j < cnt_w) && in_win;
      default:   match = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    count_d    = count_q;
    end_d      = end_q;
    tref_d     = tref_q;
    pend_vld_d = pend_vld_q;
    pend_ld    = 1'b0;
    load_out   = 1'b0;
    ctl_o      = '0;
    out_nx     = '{found: 1'b0, value: '0, time_ms: '0, last: 1'b1,
                   fill: FILL_W'(count_q)};
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        end_d  = (rend_w < cnt_w) ? rend_w : cnt_w;
        if (accept) begin
          unique case (op_i)
            OP_PUSH: begin
              ctl_o.push  = 1'b1;
              ctl_o.wrap  = full;
              count_d     = full ? count_q : count_q + 1'b1;
              load_out    = 1'b1;
              out_nx.fill = FILL_W'(count_d);
            end
            OP_CLEAR: begin
              count_d     = '0;
              load_out    = 1'b1;
              out_nx.fill = '0;
            end
            OP_GET:    state_d = (pos_w < cnt_w) ? ST_SCAN : ST_DONE;
            OP_RANGE:  state_d = ((pos_w < cnt_w) && (pos_w < rend_w)) ? ST_SCAN : ST_DONE;
            OP_WINDOW: state_d = (pos_w < cnt_w) ? ST_REF : ST_DONE;
            default:   load_out = 1'b1;
          endcase
        end
      end
      ST_REF: begin
        // first lap only picks up the reference timestamp
        ctl_o.rotate = 1'b1;
        step_d       = step_q + 1'b1;
        if (j == pos_q) begin
          tref_d = tap_time_i;
        end
        if (step_last) begin
          step_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a match is held back one word so the final one can carry last
        if (!(match && pend_vld_q) || can_load) begin
          ctl_o.rotate = 1'b1;
          step_d       = step_q + 1'b1;
          if (match) begin
            if (pend_vld_q) begin
              load_out = 1'b1;
              out_nx   = '{found: 1'b1, value: pend_val_q, time_ms: pend_time_q,
                           last: 1'b0, fill: FILL_W'(count_q)};
            end
            pend_vld_d = 1'b1;
            pend_ld    = 1'b1;
          end
          if (step_last) begin
            step_d  = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (can_load) begin
          load_out   = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
          if (pend_vld_q) begin
            out_nx = '{found: 1'b1, value: pend_val_q, time_ms: pend_time_q,
                       last: 1'b1, fill: FILL_W'(count_q)};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(op_i);
      pos_q    <= pos_w;
      before_q <= before_i;
      after_q  <= after_i;
    end
    end_q  <= end_d;
    tref_q <= tref_d;
    if (pend_ld) begin
      pend_val_q  <= tap_val_i;
      pend_time_q <= tap_time_i;
    end
    if (load_out) begin
      out_q <= out_nx;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;
  assign count_o   = count_q;

endmodule
